// ----- hdl/depth_sorted_render_list_defines.svh -----
// Assertion macros used by the render list top module.
`ifndef DEPTH_SORTED_RENDER_LIST_DEFINES_SVH
`define DEPTH_SORTED_RENDER_LIST_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define DRSL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define DRSL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/drsl_pkg.sv -----
// Types, codes and sizes shared by the render list modules.
package drsl_pkg;

  localparam int CAPACITY      = 64;
  localparam int COUNT_W       = $clog2(CAPACITY + 1);
  localparam int IDX_W         = $clog2(CAPACITY);
  localparam int READ_IDX_W    = 6;
  localparam int ENTRY_COUNT_W = 7;
  localparam int CMP_W         = (COUNT_W > READ_IDX_W) ? COUNT_W : READ_IDX_W;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic        [1:0]            cmd;
    logic signed [31:0]           sort_key;
    logic                         object_kind;
    logic        [31:0]           scale;
    logic        [15:0]           tex_width;
    logic        [15:0]           tex_height;
    logic signed [31:0]           vertical_offset;
    logic signed [15:0]           horizontal_position;
    logic signed [15:0]           scaling_compensation;
    logic        [15:0]           slice_anim;
    logic        [15:0]           slice_number;
    logic        [READ_IDX_W-1:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic        [1:0]               status;
    logic signed [31:0]              out_sort_key;
    logic                            out_kind;
    logic        [31:0]              out_scale;
    logic        [15:0]              out_width;
    logic        [15:0]              out_height;
    logic signed [31:0]              out_vertical_offset;
    logic signed [15:0]              out_horizontal_position;
    logic signed [15:0]              out_compensation;
    logic        [15:0]              out_slice_anim;
    logic        [15:0]              out_slice_number;
    logic        [ENTRY_COUNT_W-1:0] entry_count;
  } out_item_t;

  // One stored render entry.
  typedef struct packed {
    logic signed [31:0] key;
    logic               kind;
    logic        [31:0] scale;
    logic        [15:0] width;
    logic        [15:0] height;
    logic signed [31:0] voff;
    logic signed [15:0] hpos;
    logic signed [15:0] comp;
    logic        [15:0] anim;
    logic        [15:0] slice;
  } entry_t;

  // Per-cell control from the list controller.
  typedef struct packed {
    logic ins;
    logic valid;
  } cell_ctrl_t;

endpackage

// ----- hdl/drsl_in_if.sv -----
// Command channel carrying one request item.
interface drsl_in_if import drsl_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/drsl_out_if.sv -----
// Result channel carrying one response item.
interface drsl_out_if import drsl_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/drsl_cell.sv -----
// One position of the sorted list: holds an entry and shifts or takes the new one.
module drsl_cell import drsl_pkg::*; (
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     new_i,
  input  entry_t     prev_i,
  input  logic       prev_ge_i,
  output entry_t     entry_o,
  output logic       ge_o
);

  entry_t entry_q;
  entry_t entry_d;

  // A held entry with an equal or larger key stays in front of the new one.
  assign ge_o = ctrl_i.valid && ($signed(entry_q.key) >= $signed(new_i.key));

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins && !ge_o) begin
      entry_d = prev_ge_i ? new_i : prev_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ----- hdl/depth_sorted_render_list.sv -----
// Depth-sorted render list: a chain of cells kept in descending key order.
// The result of an accepted item is registered directly in the output register.
// Throughput: one item per cycle while the output is not stalled; every cell compares and shifts in the same cycle.
// Reset clears the entry count and the output valid; stored entries are not cleared,
// as only positions below the count are ever read.
module depth_sorted_render_list import drsl_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  drsl_in_if.sink   in_i,
  drsl_out_if.source out_o
);

  `include "depth_sorted_render_list_defines.svh"

  logic [COUNT_W-1:0] count_q;
  logic [COUNT_W-1:0] count_d;
  logic               out_valid_q;
  out_item_t          out_data_q;
  out_item_t          out_data_d;
  logic               in_fire;
  logic               full;
  logic               do_ins;
  entry_t             new_ent;
  entry_t             rd_ent;
  logic [IDX_W-1:0]   rd_sel;
  logic               rd_ok;

  entry_t     cell_ent [CAPACITY];
  entry_t     prev_ent [CAPACITY];
  logic       cell_ge  [CAPACITY];
  logic       prev_ge  [CAPACITY];
  cell_ctrl_t cell_ctrl[CAPACITY];

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;
  assign full       = (count_q == COUNT_W'(CAPACITY));
  assign do_ins     = in_fire && (in_i.data.cmd == CMD_INSERT) && !full;

  // Sprites carry no texture size or compensation; textures carry no offset.
  always_comb begin
    new_ent.key   = in_i.data.sort_key;
    new_ent.kind  = in_i.data.object_kind;
    new_ent.scale = in_i.data.scale;
    new_ent.hpos  = in_i.data.horizontal_position;
    new_ent.anim  = in_i.data.slice_anim;
    new_ent.slice = in_i.data.slice_number;
    if (in_i.data.object_kind) begin
      new_ent.width  = '0;
      new_ent.height = '0;
      new_ent.comp   = '0;
      new_ent.voff   = in_i.data.vertical_offset;
    end else begin
      new_ent.width  = in_i.data.tex_width;
      new_ent.height = in_i.data.tex_height;
      new_ent.comp   = in_i.data.scaling_compensation;
      new_ent.voff   = '0;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_ent[i] = new_ent;
      assign prev_ge[i]  = 1'b1;
    end else begin : g_body
      assign prev_ent[i] = cell_ent[i-1];
      assign prev_ge[i]  = cell_ge[i-1];
    end
    assign cell_ctrl[i].ins   = do_ins;
    assign cell_ctrl[i].valid = (COUNT_W'(i) < count_q);

    drsl_cell u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (cell_ctrl[i]),
      .new_i    (new_ent),
      .prev_i   (prev_ent[i]),
      .prev_ge_i(prev_ge[i]),
      .entry_o  (cell_ent[i]),
      .ge_o     (cell_ge[i])
    );
  end

  assign rd_sel = IDX_W'(in_i.data.read_index);
  assign rd_ok  = (CMP_W'(in_i.data.read_index) < CMP_W'(count_q));
  assign rd_ent = cell_ent[rd_sel];

  always_comb begin
    count_d    = count_q;
    out_data_d = '0;
    unique case (in_i.data.cmd)
      CMD_INSERT: begin
        if (full) begin
          out_data_d.status = ST_FULL;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
      CMD_READ: begin
        if (!rd_ok) begin
          out_data_d.status = ST_RANGE;
        end else begin
          out_data_d.out_sort_key            = rd_ent.key;
          out_data_d.out_kind                = rd_ent.kind;
          out_data_d.out_scale               = rd_ent.scale;
          out_data_d.out_width               = rd_ent.width;
          out_data_d.out_height              = rd_ent.height;
          out_data_d.out_vertical_offset     = rd_ent.voff;
          out_data_d.out_horizontal_position = rd_ent.hpos;
          out_data_d.out_compensation        = rd_ent.comp;
          out_data_d.out_slice_anim          = rd_ent.anim;
          out_data_d.out_slice_number        = rd_ent.slice;
        end
      end
      CMD_CLEAR: begin
        count_d = '0;
      end
      default: begin
      end
    endcase
    out_data_d.entry_count = ENTRY_COUNT_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  `DRSL_ASSERT_IMP(a_count_bound, 1'b1, count_q <= COUNT_W'(CAPACITY), "count above capacity")
  `DRSL_ASSERT_NXT(a_insert_grows, do_ins, count_q == $past(count_q) + 1'b1, "insert lost")
  `DRSL_ASSERT_NXT(a_result_follows, in_fire, out_valid_q, "no result after accepted item")
  `DRSL_ASSERT_NXT(a_count_idle, !in_fire, $stable(count_q), "count moved without an item")

endmodule

// ----- verif/depth_sorted_render_list_tb.sv -----
// Self-checking testbench for the depth-sorted render list.
`timescale 1ns / 1ps

module depth_sorted_render_list_tb;
  import drsl_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int HOLD_LEN    = 300;
  localparam int QUIET_LIMIT = 2000;

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  drsl_in_if  cmd_if ();
  drsl_out_if res_if ();

  depth_sorted_render_list uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the sorted store, updated as each item is accepted.
  entry_t    sorted_entries [CAPACITY];
  int        entries_held;
  out_item_t due_replies [$];
  dir_row_t  dir_table [$];

  int send_idle_pct;
  int stall_pct;
  int hold_requests;
  int holds_served;
  int hold_cnt;
  int mismatches;
  int quiet_cycles;
  int n_inserts, n_dropped, n_reads, n_range, n_clears;

  function automatic in_item_t mk_item(input logic [1:0] op, input logic [31:0] key,
                                       input logic kind, input logic [31:0] scl,
                                       input logic [15:0] w, input logic [15:0] h,
                                       input logic [31:0] voff, input logic [15:0] hpos,
                                       input logic [15:0] comp, input logic [15:0] anim,
                                       input logic [15:0] slc, input logic [5:0] idx);
    in_item_t c;
    c.cmd                  = op;
    c.sort_key             = key;
    c.object_kind          = kind;
    c.scale                = scl;
    c.tex_width            = w;
    c.tex_height           = h;
    c.vertical_offset      = voff;
    c.horizontal_position  = hpos;
    c.scaling_compensation = comp;
    c.slice_anim           = anim;
    c.slice_number         = slc;
    c.read_index           = idx;
    return c;
  endfunction

  function automatic out_item_t status_only(input logic [1:0] st, input int cnt);
    out_item_t r;
    r             = '0;
    r.status      = st;
    r.entry_count = 7'(cnt);
    return r;
  endfunction

  // Applies one command to the shadow store and returns the reply it should give.
  function automatic out_item_t apply_render_cmd(input in_item_t c);
    out_item_t r;
    entry_t    e;
    int        pos;
    int        i;
    r = '0;
    case (c.cmd)
      CMD_INSERT: begin
        if (entries_held >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          e.key   = c.sort_key;
          e.kind  = c.object_kind;
          e.scale = c.scale;
          e.hpos  = c.horizontal_position;
          e.anim  = c.slice_anim;
          e.slice = c.slice_number;
          // Sprites carry no texture size or compensation; textures no offset.
          e.width  = c.object_kind ? 16'd0 : c.tex_width;
          e.height = c.object_kind ? 16'd0 : c.tex_height;
          e.comp   = c.object_kind ? 16'sd0 : c.scaling_compensation;
          e.voff   = c.object_kind ? c.vertical_offset : 32'sd0;
          pos = 0;
          while (pos < entries_held &&
                 $signed(sorted_entries[pos].key) >= $signed(c.sort_key))
            pos++;
          for (i = entries_held; i > pos; i--)
            sorted_entries[i] = sorted_entries[i-1];
          sorted_entries[pos] = e;
          entries_held++;
        end
      end
      CMD_READ: begin
        if (int'(c.read_index) >= entries_held) begin
          r.status = ST_RANGE;
        end else begin
          e                         = sorted_entries[c.read_index];
          r.out_sort_key            = e.key;
          r.out_kind                = e.kind;
          r.out_scale               = e.scale;
          r.out_width               = e.width;
          r.out_height              = e.height;
          r.out_vertical_offset     = e.voff;
          r.out_horizontal_position = e.hpos;
          r.out_compensation        = e.comp;
          r.out_slice_anim          = e.anim;
          r.out_slice_number        = e.slice;
        end
      end
      CMD_CLEAR: entries_held = 0;
      default: ;
    endcase
    r.entry_count = 7'(entries_held);
    return r;
  endfunction

  function automatic in_item_t rand_cmd(input logic [1:0] op);
    in_item_t c;
    c.cmd = op;
    case ($urandom_range(7))
      0: c.sort_key = 32'h8000_0000;
      1: c.sort_key = 32'h7FFF_FFFF;
      // A narrow band of keys so that ties are frequent.
      2, 3: c.sort_key = {16'($urandom_range(3)) - 16'd1, 16'h0000};
      default: c.sort_key = $urandom;
    endcase
    c.object_kind          = 1'($urandom_range(1));
    c.scale                = $urandom;
    c.tex_width            = 16'($urandom_range(16'hFFFF));
    c.tex_height           = 16'($urandom_range(16'hFFFF));
    c.vertical_offset      = $urandom;
    c.horizontal_position  = 16'($urandom_range(16'hFFFF));
    c.scaling_compensation = 16'($urandom_range(16'hFFFF));
    c.slice_anim           = 16'($urandom_range(16'hFFFF));
    c.slice_number         = 16'($urandom_range(16'hFFFF));
    c.read_index           = 6'($urandom_range(63));
    return c;
  endfunction

  task automatic send_cmd(input in_item_t c, input bit typed, input out_item_t want);
    out_item_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= c;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    pred = apply_render_cmd(c);
    due_replies.push_back(typed ? want : pred);
    case (c.cmd)
      CMD_INSERT: begin
        n_inserts++;
        if (pred.status == ST_FULL) n_dropped++;
      end
      CMD_READ: begin
        n_reads++;
        if (pred.status == ST_RANGE) n_range++;
      end
      CMD_CLEAR: n_clears++;
      default: ;
    endcase
  endtask

  // The sender stops offering until every outstanding reply has come back.
  task automatic drain_replies();
    cmd_if.valid <= 1'b0;
    do @(posedge clk_i); while (due_replies.size() != 0);
  endtask

  task automatic fill_past_capacity();
    int n;
    int k;
    n = CAPACITY - entries_held + $urandom_range(1, 3);
    for (k = 0; k < n; k++) send_cmd(rand_cmd(CMD_INSERT), 1'b0, '0);
  endtask

  task automatic random_traffic(input int budget);
    int       sent;
    int       pick;
    int       n;
    int       k;
    in_item_t c;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        n = CAPACITY - entries_held + 2;
        fill_past_capacity();
      end else if (pick < 14) begin
        n = 1;
        send_cmd(rand_cmd(CMD_CLEAR), 1'b0, '0);
      end else if (pick < 20) begin
        // Walk the list from the head and a little past its end.
        n = (entries_held + 2 > CAPACITY) ? CAPACITY : entries_held + 2;
        for (k = 0; k < n; k++) begin
          c            = rand_cmd(CMD_READ);
          c.read_index = 6'(k);
          send_cmd(c, 1'b0, '0);
        end
      end else if (pick < 24) begin
        n = 1;
        send_cmd(rand_cmd(2'($urandom_range(3))), 1'b0, '0);
      end else begin
        n = $urandom_range(1, 16);
        for (k = 0; k < n; k++) begin
          if ($urandom_range(99) < 65) begin
            send_cmd(rand_cmd(CMD_INSERT), 1'b0, '0);
          end else begin
            c = rand_cmd(CMD_READ);
            if (entries_held > 0 && $urandom_range(99) < 80)
              c.read_index = 6'($urandom_range(entries_held - 1));
            send_cmd(c, 1'b0, '0);
          end
        end
      end
      sent += n;
    end
  endtask

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    out_item_t got;
    if (res_if.valid && res_if.ready) begin
      got = res_if.data;
      if (due_replies.size() == 0) begin
        mismatches++;
        $display("%0t: reply with none expected: expected nothing, got %h", $time, got);
      end else begin
        want = due_replies.pop_front();
        check_field("status", want.status, got.status);
        check_field("sort key", want.out_sort_key, got.out_sort_key);
        check_field("kind", want.out_kind, got.out_kind);
        check_field("scale", want.out_scale, got.out_scale);
        check_field("width", want.out_width, got.out_width);
        check_field("height", want.out_height, got.out_height);
        check_field("vertical offset", want.out_vertical_offset, got.out_vertical_offset);
        check_field("horizontal position", want.out_horizontal_position,
                    got.out_horizontal_position);
        check_field("compensation", want.out_compensation, got.out_compensation);
        check_field("slice anim", want.out_slice_anim, got.out_slice_anim);
        check_field("slice number", want.out_slice_number, got.out_slice_number);
        check_field("entry count", want.entry_count, got.entry_count);
      end
    end
  end

  // Receiver: random stalls, or a long hold-off whenever one is requested.
  always @(posedge clk_i) begin
    if (holds_served != hold_requests) begin
      res_if.ready <= 1'b0;
      if (hold_cnt == HOLD_LEN - 1) begin
        hold_cnt     <= 0;
        holds_served <= holds_served + 1;
      end else begin
        hold_cnt <= hold_cnt + 1;
      end
    end else begin
      res_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cmd_if.valid  = 1'b0;
    cmd_if.data   = '0;
    res_if.ready  = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_requests = 0;
    holds_served  = 0;
    hold_cnt      = 0;
    mismatches    = 0;
    quiet_cycles  = 0;
    entries_held  = 0;
    n_inserts = 0; n_dropped = 0; n_reads = 0; n_range = 0; n_clears = 0;

    dir_table.push_back('{mk_item(CMD_READ, 32'h0, 1'b0, 32'h0, 16'h0, 16'h0, 32'h0,
                         16'h0, 16'h0, 16'h0, 16'h0, 6'd0), 1'b1, status_only(ST_RANGE, 0)});
    dir_table.push_back('{mk_item(CMD_UNUSED, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 16'hFFFF,
                         16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         6'd63), 1'b1, status_only(ST_OK, 0)});
    dir_table.push_back('{mk_item(CMD_CLEAR, 32'h0, 1'b0, 32'h0, 16'h0, 16'h0, 32'h0,
                         16'h0, 16'h0, 16'h0, 16'h0, 6'd0), 1'b1, status_only(ST_OK, 0)});
    // Texture with every field but the key at its top: the offset must be dropped.
    dir_table.push_back('{mk_item(CMD_INSERT, 32'h0, 1'b0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                         32'h7FFF_FFFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 6'd63),
                         1'b1, status_only(ST_OK, 1)});
    // Sprite at the largest key: size and compensation must be dropped.
    dir_table.push_back('{mk_item(CMD_INSERT, 32'h7FFF_FFFF, 1'b1, 32'h0, 16'h1234, 16'h5678,
                         32'h8000_0000, 16'h8000, 16'h8000, 16'h0, 16'h0, 6'd0),
                         1'b1, status_only(ST_OK, 2)});
    dir_table.push_back('{mk_item(CMD_INSERT, 32'h8000_0000, 1'b0, 32'h0001_0000, 16'h0,
                         16'h0, 32'hFFFF_FFFF, 16'hFFFF, 16'h8000, 16'h1, 16'h2, 6'd0),
                         1'b1, status_only(ST_OK, 3)});
    dir_table.push_back('{mk_item(CMD_INSERT, 32'hFFFF_FFFF, 1'b1, 32'h0, 16'h0, 16'h0, 32'h0,
                         16'h0, 16'h0, 16'h0, 16'h0, 6'd0), 1'b1, status_only(ST_OK, 4)});
    // Same key as an earlier entry: it must land behind that one.
    dir_table.push_back('{mk_item(CMD_INSERT, 32'h0, 1'b0, 32'h0000_8000, 16'h00A0, 16'h0040,
                         32'h0, 16'h0100, 16'hFFFE, 16'h3, 16'h4, 6'd63),
                         1'b1, status_only(ST_OK, 5)});
    for (int r = 0; r < 5; r++)
      dir_table.push_back('{mk_item(CMD_READ, 32'h0, 1'b0, 32'h0, 16'h0, 16'h0, 32'h0,
                           16'h0, 16'h0, 16'h0, 16'h0, 6'(r)), 1'b0, '0});
    dir_table.push_back('{mk_item(CMD_READ, 32'h0, 1'b0, 32'h0, 16'h0, 16'h0, 32'h0,
                         16'h0, 16'h0, 16'h0, 16'h0, 6'd5), 1'b1, status_only(ST_RANGE, 5)});
    dir_table.push_back('{mk_item(CMD_READ, 32'h0, 1'b0, 32'h0, 16'h0, 16'h0, 32'h0,
                         16'h0, 16'h0, 16'h0, 16'h0, 6'd63), 1'b1, status_only(ST_RANGE, 5)});
    dir_table.push_back('{mk_item(CMD_INSERT, 32'h0001_0000, 1'b1, 32'h0002_0000, 16'hFFFF,
                         16'hFFFF, 32'h8000_0000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0, 6'd0),
                         1'b1, status_only(ST_OK, 6)});
    dir_table.push_back('{mk_item(CMD_READ, 32'h0, 1'b0, 32'h0, 16'h0, 16'h0, 32'h0,
                         16'h0, 16'h0, 16'h0, 16'h0, 6'd1), 1'b0, '0});
    dir_table.push_back('{mk_item(CMD_READ, 32'h0, 1'b0, 32'h0, 16'h0, 16'h0, 32'h0,
                         16'h0, 16'h0, 16'h0, 16'h0, 6'd6), 1'b1, status_only(ST_RANGE, 6)});
    dir_table.push_back('{mk_item(CMD_CLEAR, 32'h0, 1'b0, 32'h0, 16'h0, 16'h0, 32'h0,
                         16'h0, 16'h0, 16'h0, 16'h0, 6'd0), 1'b1, status_only(ST_OK, 0)});
    dir_table.push_back('{mk_item(CMD_READ, 32'h0, 1'b0, 32'h0, 16'h0, 16'h0, 32'h0,
                         16'h0, 16'h0, 16'h0, 16'h0, 6'd0), 1'b1, status_only(ST_RANGE, 0)});
    dir_table.push_back('{mk_item(CMD_INSERT, 32'h8000_0000, 1'b0, 32'h0, 16'h0, 16'h0,
                         32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 6'd0), 1'b1, status_only(ST_OK, 1)});
    dir_table.push_back('{mk_item(CMD_READ, 32'h0, 1'b0, 32'h0, 16'h0, 16'h0, 32'h0,
                         16'h0, 16'h0, 16'h0, 16'h0, 6'd0), 1'b0, '0});
    dir_table.push_back('{mk_item(CMD_UNUSED, 32'h0, 1'b0, 32'h0, 16'h0, 16'h0, 32'h0,
                         16'h0, 16'h0, 16'h0, 16'h0, 6'd0), 1'b1, status_only(ST_OK, 1)});

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_table[r]) send_cmd(dir_table[r].stim, dir_table[r].typed, dir_table[r].want);
    drain_replies();

    // The receiver holds off while the store is filled and overrun, so the
    // block backs up and has to stall its input.
    hold_requests++;
    fill_past_capacity();
    random_traffic(185);
    drain_replies();

    send_idle_pct = 67;
    random_traffic(185);
    send_idle_pct = 0;
    stall_pct     = 67;
    random_traffic(185);
    send_idle_pct = 24;
    stall_pct     = 24;
    random_traffic(185);

    drain_replies();
    repeat (10) @(posedge clk_i);

    $display("Covered %0d inserts (%0d dropped on a full store), %0d reads", n_inserts,
             n_dropped, n_reads);
    $display("(%0d past the end) and %0d clears, under four idling patterns.", n_range,
             n_clears);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
